>>> src/ili_pkg.sv
package ili_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  localparam data_t NO_VALUE = -32'sd1;

  typedef enum logic [2:0] {
    MODE_READ = 3'd0,
    MODE_HEAD = 3'd1,
    MODE_TAIL = 3'd2,
    MODE_AT   = 3'd3,
    MODE_DEL  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Controller to datapath: execute the request on the input ports this cycle.
  typedef struct packed {
    logic exec;
  } dp_cmd_t;

endpackage

>>> src/indexed_list_insert_delete.sv
// Ordered list of up to 16 signed 32-bit values, packed at positions 0..count-1.
// Input channel (in_valid / in_stall): one request carries in_mode (read, insert
// at head, append at tail, insert before a position, delete at a position),
// in_position and in_new_value.
// Result channel (out_valid / out_stall): one result per request with the value
// read (-1 when not a valid read), a status (done, position out of range, list
// full) and the count after the request.
// Latency: the result is valid the cycle after the request is accepted.
// Throughput: one request per cycle unless a held result is stalled by out_stall;
// the whole list is a row of registers that shifts by one place at once, so no operation iterates.
// The result sits in an output register; a new request is taken while the
// receiver stalls only if the held result is not blocked, i.e. in_stall rises
// when a result is held and out_stall is high.
// Reset (rst_n low, synchronous) empties the list and drops any held result;
// stored values are not cleared, as positions at or above the count are never
// read.
module indexed_list_insert_delete (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_mode,
  input  logic [ili_pkg::POS_W-1:0]       in_position,
  input  logic signed [ili_pkg::DATA_W-1:0] in_new_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [ili_pkg::DATA_W-1:0] out_read_value,
  output logic [1:0]                      out_status,
  output logic [ili_pkg::CNT_W-1:0]       out_count
);

  ili_pkg::dp_cmd_t cmd;

  ili_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ili_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_mode),
    .in_position    (in_position),
    .in_new_value   (in_new_value),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count)
  );

endmodule

>>> src/ili_ctrl.sv
module ili_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output ili_pkg::dp_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  // Take a new request when no result is held, or when the held result leaves in the same cycle.
  assign in_stall  = (state_r == ST_HOLD) && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cmd.exec  = accept;
  assign out_valid = (state_r == ST_HOLD);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (accept) state_nxt = ST_HOLD;
        else if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/ili_datapath.sv
module ili_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ili_pkg::dp_cmd_t                cmd,
  input  logic [2:0]                      in_mode,
  input  logic [ili_pkg::POS_W-1:0]       in_position,
  input  logic signed [ili_pkg::DATA_W-1:0] in_new_value,
  output logic signed [ili_pkg::DATA_W-1:0] out_read_value,
  output logic [1:0]                      out_status,
  output logic [ili_pkg::CNT_W-1:0]       out_count
);

  ili_pkg::data_t                entries_r   [ili_pkg::CAPACITY];
  ili_pkg::data_t                entries_nxt [ili_pkg::CAPACITY];
  logic [ili_pkg::CNT_W-1:0]     count_r;
  logic [ili_pkg::CNT_W-1:0]     count_nxt;
  ili_pkg::data_t                rd_r;
  ili_pkg::data_t                rd_nxt;
  ili_pkg::status_t              st_r;
  ili_pkg::status_t              st_nxt;
  logic [ili_pkg::POS_W-1:0]     cnt_ext;
  logic [ili_pkg::POS_W-1:0]     ins_pos;
  logic                          do_ins;

  assign cnt_ext = ili_pkg::POS_W'(count_r);

  always_comb begin
    entries_nxt = entries_r;
    count_nxt   = count_r;
    rd_nxt      = ili_pkg::NO_VALUE;
    st_nxt      = ili_pkg::STAT_DONE;
    ins_pos     = '0;
    do_ins      = 1'b0;

    case (ili_pkg::mode_t'(in_mode))
      ili_pkg::MODE_READ: begin
        if (in_position < cnt_ext) rd_nxt = entries_r[in_position[ili_pkg::IDX_W-1:0]];
        else st_nxt = ili_pkg::STAT_RANGE;
      end
      ili_pkg::MODE_HEAD: begin
        do_ins  = 1'b1;
        ins_pos = '0;
      end
      ili_pkg::MODE_TAIL: begin
        do_ins  = 1'b1;
        ins_pos = cnt_ext;
      end
      ili_pkg::MODE_AT: begin
        do_ins  = 1'b1;
        ins_pos = in_position;
      end
      ili_pkg::MODE_DEL: begin
        if (in_position >= cnt_ext) begin
          st_nxt = ili_pkg::STAT_RANGE;
        end else begin
          // Pull every cell from the position up to the second-to-last down by one; the last cell keeps its value.
          for (int i = 0; i < ili_pkg::CAPACITY - 1; i++) begin
            if (ili_pkg::POS_W'(i) >= in_position)
              entries_nxt[ili_pkg::IDX_W'(i)] = entries_r[ili_pkg::IDX_W'(i + 1)];
          end
          count_nxt = count_r - 1'b1;
        end
      end
      default: ;
    endcase

    if (do_ins) begin
      if (ins_pos > cnt_ext) begin
        st_nxt = ili_pkg::STAT_RANGE;
      end else if (count_r == ili_pkg::CNT_W'(ili_pkg::CAPACITY)) begin
        st_nxt = ili_pkg::STAT_FULL;
      end else begin
        // Push cells after the position up by one, drop the new value in place.
        for (int i = 0; i < ili_pkg::CAPACITY; i++) begin
          if (ili_pkg::POS_W'(i) == ins_pos)
            entries_nxt[ili_pkg::IDX_W'(i)] = in_new_value;
          else if (ili_pkg::POS_W'(i) > ins_pos)
            entries_nxt[ili_pkg::IDX_W'(i)] =
              entries_r[ili_pkg::IDX_W'((i > 0) ? i - 1 : 0)];
        end
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      entries_r <= entries_nxt;
      rd_r      <= rd_nxt;
      st_r      <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign out_read_value = rd_r;
  assign out_status     = st_r;
  assign out_count      = count_r;

endmodule

>>> src/ili_checker.sv
module ili_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [ili_pkg::DATA_W-1:0] out_read_value,
  input logic [1:0]                      out_status,
  input logic [ili_pkg::CNT_W-1:0]       out_count
);

  // An accepted request always yields a result in the next cycle.
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request produced no result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= ili_pkg::CNT_W'(ili_pkg::CAPACITY))
    else $error("count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ili_pkg::STAT_FULL
      |-> out_count == ili_pkg::CNT_W'(ili_pkg::CAPACITY))
    else $error("full status with free room");

  a_value_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_value != ili_pkg::NO_VALUE |-> out_status == ili_pkg::STAT_DONE)
    else $error("value returned with failure status");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind indexed_list_insert_delete ili_checker u_ili_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_value (out_read_value),
  .out_status     (out_status),
  .out_count      (out_count)
);
